FILE: rtl/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/irf_pkg.sv
// ---------------------------------------------------------------------------
// irf_pkg
// Types and constants for the IPv4 receive filter.
// ---------------------------------------------------------------------------
package irf_pkg;

    localparam logic [2:0] V_UDP       = 3'd0;
    localparam logic [2:0] V_TCP       = 3'd1;
    localparam logic [2:0] V_UNKNOWN   = 3'd2;
    localparam logic [2:0] V_SHORT_HDR = 3'd3;
    localparam logic [2:0] V_NOT_OURS  = 3'd4;
    localparam logic [2:0] V_BAD_LEN   = 3'd5;
    localparam logic [2:0] V_SHORT_PAY = 3'd6;

    localparam logic       REG_OWN_ADDR  = 1'b0;
    localparam logic       REG_OWN_VALID = 1'b1;

    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [3:0] IHL_MASK  = 4'hf;

    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  payload_byte;
        logic [2:0]  verdict;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] payload_length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } t_item;

    typedef struct packed {
        logic [0:0]  index;
        logic        bad_index;
        logic [31:0] data;
    } t_cfg;

endpackage

FILE: rtl/irf_if.sv
// ---------------------------------------------------------------------------
// irf_if
// Valid/ready channel interfaces for the IPv4 receive filter.
// ---------------------------------------------------------------------------
interface irf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       end_of_frame;
    modport source (output valid, frame_byte, end_of_frame, input ready);
    modport sink   (input valid, frame_byte, end_of_frame, output ready);
endinterface

interface irf_out_if;
    logic        valid;
    logic        ready;
    logic        is_verdict;
    logic [7:0]  payload_byte;
    logic [2:0]  verdict;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] payload_length;
    logic        last;
    modport source (output valid, is_verdict, payload_byte, verdict, protocol_number,
                    source_address, destination_address, payload_length, last,
                    input ready);
    modport sink   (input valid, is_verdict, payload_byte, verdict, protocol_number,
                    source_address, destination_address, payload_length, last,
                    output ready);
endinterface

interface irf_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/irf_queue.sv
// ---------------------------------------------------------------------------
// irf_queue
// Small FIFO between the byte front end and the result back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module irf_queue
    import irf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_item  o_data,
    output logic   o_empty
);
    t_item      r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 2'd1;
            if (i_pop && !o_empty) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'((i_push && !o_full) ? 1 : 0) - 3'((i_pop && !o_empty) ? 1 : 0);
        end
    end

    `ASSERT_IMPLY(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd4, "queue count overflow")
    `ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, o_full && !i_pop, o_full, "full dropped without pop")
endmodule

FILE: rtl/irf_engine.sv
// ---------------------------------------------------------------------------
// irf_engine
// Per-byte header capture, filtering and result generation.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module irf_engine
    import irf_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [31:0] i_own_addr,
    input  logic        i_own_valid,
    output logic        o_busy,
    output logic        o_valid,
    output t_result     o_res,
    input  logic        i_ready
);
    localparam logic [15:0] MAXP = 16'(MAX_PACKET_BYTES);

    logic [15:0] r_pos, r_fwd;
    logic [31:0] r_hw [5];
    logic        r_acc;
    logic [2:0]  r_drop;
    // two-entry output buffer
    t_result     r_o0, r_o1, n_o0, n_o1;
    logic        r_v0, r_v1, n_v0, n_v1;

    logic [7:0]  b;
    logic        eof;
    logic [15:0] hl, tl, plen, start;
    logic        pay, in_max, in_hdr, dst_ours;
    logic [15:0] n_pos;
    logic [31:0] n_hw4;
    logic [2:0]  w_idx;
    t_result     pr, vr;

    // pop only when both result slots are free after this cycle's drain
    assign o_pop = !i_empty && !r_v1 && (!r_v0 || i_ready);
    assign o_busy = !i_empty || r_v0 || r_v1;
    assign b   = i_item.frame_byte;
    assign eof = i_item.end_of_frame;

    assign in_max = r_pos < MAXP;
    assign in_hdr = r_pos < 16'd20;
    assign w_idx  = r_pos[4:2];
    assign hl   = {10'd0, r_hw[0][27:24] & IHL_MASK, 2'b00};
    assign tl   = r_hw[0][15:0];
    assign plen = tl - hl;
    assign start = (hl > 16'd20) ? hl : 16'd20;
    assign pay  = in_max && !in_hdr && r_acc && (r_pos >= start) && (r_fwd != plen);
    assign n_pos = in_max ? r_pos + 16'd1 : r_pos;
    assign n_hw4 = {r_hw[4][23:0], b};
    assign dst_ours = (n_hw4 == 32'hffffffff) || (i_own_valid && n_hw4 == i_own_addr);

    always_comb begin
        logic [15:0] n_fwd;
        pr = '0;
        pr.payload_byte = b;
        vr = '0;
        vr.is_verdict = 1'b1;
        vr.last = 1'b1;
        n_fwd = r_fwd + (pay ? 16'd1 : 16'd0);
        if (n_pos < 16'd20) begin
            vr.verdict = V_SHORT_HDR;
        end else if (r_pos == 16'd19) begin
            vr.protocol_number = r_hw[2][23:16];
            vr.source_address = r_hw[3];
            vr.destination_address = n_hw4;
            if (!dst_ours) begin
                vr.verdict = V_NOT_OURS;
                vr.payload_length = plen;
            end else if (tl < hl) begin
                vr.verdict = V_BAD_LEN;
            end else begin
                vr.payload_length = plen;
                vr.verdict = (plen != 16'd0) ? V_SHORT_PAY :
                             (r_hw[2][23:16] == PROTO_UDP) ? V_UDP :
                             (r_hw[2][23:16] == PROTO_TCP) ? V_TCP : V_UNKNOWN;
            end
        end else begin
            vr.protocol_number = r_hw[2][23:16];
            vr.source_address = r_hw[3];
            vr.destination_address = r_hw[4];
            if (!r_acc) begin
                vr.verdict = r_drop;
                if (r_drop != V_BAD_LEN) vr.payload_length = plen;
            end else begin
                vr.payload_length = plen;
                vr.verdict = (n_fwd != plen) ? V_SHORT_PAY :
                             (r_hw[2][23:16] == PROTO_UDP) ? V_UDP :
                             (r_hw[2][23:16] == PROTO_TCP) ? V_TCP : V_UNKNOWN;
            end
        end
    end

    always_comb begin
        n_o0 = r_o0;
        n_o1 = r_o1;
        n_v0 = r_v0;
        n_v1 = r_v1;
        if (i_ready && r_v0) begin
            n_o0 = r_o1;
            n_v0 = r_v1;
            n_v1 = 1'b0;
        end
        if (o_pop) begin
            if (pay && eof) begin
                n_o0 = pr; n_v0 = 1'b1; n_o1 = vr; n_v1 = 1'b1;
            end else if (pay || eof) begin
                if (!n_v0) begin
                    n_o0 = pay ? pr : vr; n_v0 = 1'b1;
                end else begin
                    n_o1 = pay ? pr : vr; n_v1 = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw[0] <= '0; r_hw[1] <= '0; r_hw[2] <= '0; r_hw[3] <= '0; r_hw[4] <= '0;
        end else if (o_pop) begin
            if (eof) begin
                r_hw[0] <= '0; r_hw[1] <= '0; r_hw[2] <= '0; r_hw[3] <= '0; r_hw[4] <= '0;
            end else if (in_max && in_hdr) begin
                r_hw[w_idx] <= {r_hw[w_idx][23:0], b};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_fwd <= '0; r_acc <= 1'b0; r_drop <= '0;
            r_v0 <= 1'b0; r_v1 <= 1'b0; r_o0 <= '0; r_o1 <= '0;
        end else begin
            r_o0 <= n_o0; r_o1 <= n_o1; r_v0 <= n_v0; r_v1 <= n_v1;
            if (o_pop) begin
                if (eof) begin
                    r_pos <= '0; r_fwd <= '0; r_acc <= 1'b0; r_drop <= '0;
                end else begin
                    r_pos <= n_pos;
                    if (pay) r_fwd <= r_fwd + 16'd1;
                    if (in_max && r_pos == 16'd19) begin
                        if (!dst_ours) r_drop <= V_NOT_OURS;
                        else if (tl < hl) r_drop <= V_BAD_LEN;
                        else r_acc <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_valid = r_v0;
    assign o_res   = r_o0;

    `ASSERT_IMPLY(a_v1_needs_v0, i_clk, i_rst_n, r_v1, r_v0, "second slot without first")
    `ASSERT_IMPLY(a_fwd_bound, i_clk, i_rst_n, r_fwd != 16'd0, r_acc, "forwarded bytes on drop")
    `ASSERT_NEXT(a_eof_clear, i_clk, i_rst_n, o_pop && i_item.end_of_frame, r_pos == 16'd0,
                 "position not cleared after frame")
endmodule

FILE: rtl/ipv4_receive_filter.sv
// ---------------------------------------------------------------------------
// ipv4_receive_filter
// Byte-serial IPv4 receive filter: header capture, address and length
// checks, payload forwarding and a verdict per frame.
// ---------------------------------------------------------------------------
// channel   dir   transaction
// s_in      in    one frame byte plus end-of-frame flag
// m_out     out   one payload byte or one packet verdict
// s_cfg     in    register write (0 own_address, 1 own_address_valid)
//
// One byte per cycle while m_out is ready; a byte that yields a payload result
// and a verdict fills both output buffer slots and holds off the next byte.
// A four-entry queue decouples byte intake from the result buffer.
// Reset is synchronous; the block accepts bytes the cycle after reset.
// Output stalls back up through the queue into s_in.ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module ipv4_receive_filter
    import irf_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic i_clk,
    input  logic i_rst_n,
    irf_in_if.sink    s_in,
    irf_out_if.source m_out,
    irf_cfg_if.sink   s_cfg
);
    logic [31:0] r_own_addr;
    logic        r_own_valid;
    logic        full, empty, pop, busy;
    t_item       qi, qo;
    t_result     res;

    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= '0; r_own_valid <= 1'b0;
        end else if (s_cfg.valid) begin
            if (s_cfg.index == 8'(REG_OWN_ADDR)) r_own_addr <= s_cfg.data;
            else if (s_cfg.index == 8'(REG_OWN_VALID)) r_own_valid <= s_cfg.data[0];
        end
    end

    assign qi.frame_byte = s_in.frame_byte;
    assign qi.end_of_frame = s_in.end_of_frame;
    assign s_in.ready = !full;

    irf_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(s_in.valid), .i_data(qi), .o_full(full),
        .i_pop(pop), .o_data(qo), .o_empty(empty)
    );

    irf_engine #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_engine (
        .i_clk, .i_rst_n,
        .i_empty(empty), .i_item(qo), .o_pop(pop),
        .i_own_addr(r_own_addr), .i_own_valid(r_own_valid), .o_busy(busy),
        .o_valid(m_out.valid), .o_res(res), .i_ready(m_out.ready)
    );

    assign m_out.is_verdict = res.is_verdict;
    assign m_out.payload_byte = res.payload_byte;
    assign m_out.verdict = res.verdict;
    assign m_out.protocol_number = res.protocol_number;
    assign m_out.source_address = res.source_address;
    assign m_out.destination_address = res.destination_address;
    assign m_out.payload_length = res.payload_length;
    assign m_out.last = res.last;

    `ASSERT_IMPLY(a_out_last, i_clk, i_rst_n, m_out.valid, m_out.last == m_out.is_verdict,
                  "last must mark verdicts")
    `ASSERT_IMPLY(a_idle_out, i_clk, i_rst_n, !busy, !m_out.valid, "output valid while idle")
    `ASSERT_IMPLY(a_pay_fields, i_clk, i_rst_n, m_out.valid && !m_out.is_verdict,
                  m_out.verdict == V_UDP, "payload result carries verdict")
endmodule
